@@ sv/ils_pkg.sv @@
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants for the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int unsigned LIST_CAPACITY_DEF = 1024;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned POS_W   = 11;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned STAT_W  = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ   = 3'd0,
        KIND_FRONT  = 3'd1,
        KIND_BACK   = 3'd2,
        KIND_AT     = 3'd3,
        KIND_DELETE = 3'd4
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDWAIT,
        S_INS,
        S_INSW,
        S_DEL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        t_status                   status;
    } t_result;

endpackage

@@ sv/ils_ram.sv @@
// ----------------------------------------------------------------------------
// ils_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ils_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [ils_pkg::VALUE_W-1:0]  i_wdata,
    input  logic                         i_re,
    input  logic [AW-1:0]                i_raddr,
    output logic [ils_pkg::VALUE_W-1:0]  o_rdata
);
    import ils_pkg::*;

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/ils_seq.sv @@
// ----------------------------------------------------------------------------
// ils_seq
// Operation sequencer: decodes an operation, walks the entry store one entry
// per cycle to open or close a gap, and keeps the entry count.
// ----------------------------------------------------------------------------
module ils_seq #(
    parameter int unsigned CAPACITY = 1024,
    parameter int unsigned AW       = 10,
    parameter int unsigned CW       = 11
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_op_valid,
    output logic                              o_op_ready,
    input  logic [ils_pkg::KIND_W-1:0]        i_kind,
    input  logic [ils_pkg::POS_W-1:0]         i_position,
    input  logic signed [ils_pkg::VALUE_W-1:0] i_value,
    output logic                              o_res_valid,
    input  logic                              i_res_take,
    output ils_pkg::t_result                  o_res,
    output logic                              o_we,
    output logic [AW-1:0]                     o_waddr,
    output logic [ils_pkg::VALUE_W-1:0]       o_wdata,
    output logic                              o_re,
    output logic [AW-1:0]                     o_raddr,
    input  logic [ils_pkg::VALUE_W-1:0]       i_rdata
);
    import ils_pkg::*;

    localparam int unsigned MW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_pos, n_pos;
    logic [AW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_count, n_count;
    logic [VALUE_W-1:0] r_val, n_val;
    t_result            r_res, n_res;
    logic               r_use_rd, n_use_rd;

    t_kind         kind;
    logic [MW-1:0] pos_x, cnt_x;
    logic          rd_ok, ins_range, full, append, del_last, is_ins;
    logic          ins_end, del_end;

    assign kind   = t_kind'(i_kind);
    assign cnt_x  = MW'(r_count);
    assign is_ins = (kind == KIND_FRONT) || (kind == KIND_BACK) || (kind == KIND_AT);

    always_comb begin
        case (kind)
            KIND_FRONT: pos_x = '0;
            KIND_BACK:  pos_x = cnt_x;
            default:    pos_x = MW'(i_position);
        endcase
    end

    assign rd_ok     = pos_x < cnt_x;
    assign ins_range = pos_x > cnt_x;
    assign full      = r_count == CAP_C;
    assign append    = pos_x == cnt_x;
    assign del_last  = pos_x == (cnt_x - MW'(1));
    assign ins_end   = r_idx == r_pos;
    assign del_end   = CW'(r_idx) == (r_count - CW'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    n_state = S_DONE;
                    if (kind == KIND_READ && rd_ok) begin
                        n_state = S_RDWAIT;
                    end else if (is_ins && !ins_range && !full && !append) begin
                        n_state = S_INS;
                    end else if (kind == KIND_DELETE && rd_ok && !del_last) begin
                        n_state = S_DEL;
                    end
                end
            end
            S_RDWAIT: n_state = S_DONE;
            S_INS:    n_state = ins_end ? S_INSW : S_INS;
            S_INSW:   n_state = S_DONE;
            S_DEL:    n_state = del_end ? S_DONE : S_DEL;
            S_DONE:   n_state = i_res_take ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath registers and store accesses.
    always_comb begin
        n_pos    = r_pos;
        n_idx    = r_idx;
        n_count  = r_count;
        n_val    = r_val;
        n_res    = r_res;
        n_use_rd = r_use_rd;
        o_we     = 1'b0;
        o_waddr  = r_pos;
        o_wdata  = r_val;
        o_re     = 1'b0;
        o_raddr  = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    n_pos    = AW'(pos_x);
                    n_val    = i_value;
                    n_use_rd = 1'b0;
                    n_res.read_value = '0;
                    n_res.status     = ST_DONE;
                    case (kind)
                        KIND_READ: begin
                            if (rd_ok) begin
                                o_re     = 1'b1;
                                o_raddr  = AW'(pos_x);
                                n_use_rd = 1'b1;
                            end else begin
                                n_res.read_value = '1;
                                n_res.status     = ST_RANGE;
                            end
                        end
                        KIND_FRONT, KIND_BACK, KIND_AT: begin
                            if (ins_range) begin
                                n_res.status = ST_RANGE;
                            end else if (full) begin
                                n_res.status = ST_FULL;
                            end else if (append) begin
                                o_we    = 1'b1;
                                o_waddr = AW'(pos_x);
                                o_wdata = i_value;
                                n_count = r_count + CW'(1);
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = AW'(r_count - CW'(1));
                                n_idx   = AW'(r_count - CW'(1));
                            end
                        end
                        KIND_DELETE: begin
                            if (!rd_ok) begin
                                n_res.status = ST_RANGE;
                            end else if (del_last) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = AW'(pos_x + MW'(1));
                                n_idx   = AW'(pos_x + MW'(1));
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INS: begin
                // Move entry idx up by one; the read of idx-1 never hits idx+1.
                o_we    = 1'b1;
                o_waddr = r_idx + AW'(1);
                o_wdata = i_rdata;
                if (!ins_end) begin
                    o_re    = 1'b1;
                    o_raddr = r_idx - AW'(1);
                    n_idx   = r_idx - AW'(1);
                end
            end
            S_INSW: begin
                o_we    = 1'b1;
                o_waddr = r_pos;
                o_wdata = r_val;
                n_count = r_count + CW'(1);
            end
            S_DEL: begin
                o_we    = 1'b1;
                o_waddr = r_idx - AW'(1);
                o_wdata = i_rdata;
                if (del_end) begin
                    n_count = r_count - CW'(1);
                end else begin
                    o_re    = 1'b1;
                    o_raddr = r_idx + AW'(1);
                    n_idx   = r_idx + AW'(1);
                end
            end
            default: ;
        endcase
    end

    // Outputs.
    always_comb begin
        o_op_ready  = r_state == S_IDLE;
        o_res_valid = r_state == S_DONE;
        o_res       = r_res;
        if (r_use_rd) begin
            o_res.read_value = i_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_res    <= n_res;
        r_use_rd <= n_use_rd;
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    a_shift_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS || r_state == S_DEL) |-> (CW'(r_idx) < r_count))
        else $error("shift index outside the list");

    a_count_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE || r_state == S_RDWAIT) |=> $stable(r_count))
        else $error("entry count changed outside an update");

endmodule

@@ sv/indexed_list_store.sv @@
// Throughput: one operation at a time; a shift moves one entry per cycle,
//   bounded by the single read and single write port of the entry store.
// Reset: synchronous active low; empties the list, store contents are kept.
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of signed 32-bit values with read, insert and delete by
// position, held in a synchronous entry store.
// ----------------------------------------------------------------------------
module indexed_list_store #(
    parameter int unsigned LIST_CAPACITY = ils_pkg::LIST_CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [ils_pkg::KIND_W-1:0]         i_kind,
    input  logic [ils_pkg::POS_W-1:0]          i_position,
    input  logic signed [ils_pkg::VALUE_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [ils_pkg::VALUE_W-1:0] o_read_value,
    output logic [ils_pkg::STAT_W-1:0]         o_status
);
    import ils_pkg::*;

    localparam int unsigned AW = $clog2(LIST_CAPACITY);
    localparam int unsigned CW = $clog2(LIST_CAPACITY + 1);

    logic             we, re, res_valid, res_take;
    logic [AW-1:0]    waddr, raddr;
    logic [VALUE_W-1:0] wdata, rdata;
    t_result          res;
    t_result          r_out;
    logic             r_out_valid;

    // The sequencer drives the store; the store hands back one read beat in the
    // cycle after the read, which the sequencer forwards into its shift writes and read results.
    ils_ram #(.DEPTH(LIST_CAPACITY), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ils_seq #(.CAPACITY(LIST_CAPACITY), .AW(AW), .CW(CW)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (i_valid),
        .o_op_ready  (o_ready),
        .i_kind      (i_kind),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    // Output register: a result beat waits here, so the sequencer returns to
    // idle and takes the next operation while the consumer stalls.
    assign res_take = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
        if (res_take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_out.read_value;
    assign o_status     = r_out.status;

endmodule
